>>> hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants of the two-level page table walker: command, result
// and status codes, entry flag bits, walk phases and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int PAGE_BITS  = 12;
    localparam int INDEX_BITS = 10;
    localparam int FRAME_BITS = 32 - PAGE_BITS;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_XLATE = 2'd0,
        CMD_MAP   = 2'd1,
        CMD_UNMAP = 2'd2,
        CMD_RESP  = 2'd3
    } cmd_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    // Completion status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_PRS = 2'd1,
        ST_NO_MEM  = 2'd2
    } status_t;

    // Walk phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_WAIT_DIR  = 3'b010,
        PH_WAIT_LEAF = 3'b100
    } phase_t;

    // Entry flag bits
    localparam logic [PAGE_BITS-1:0] ENT_PRESENT = 12'h001;
    localparam logic [PAGE_BITS-1:0] ENT_WRITE   = 12'h002;
    localparam logic [PAGE_BITS-1:0] ENT_USER    = 12'h004;
    localparam logic [PAGE_BITS-1:0] ENT_PAT     = 12'h080;
    localparam logic [PAGE_BITS-1:0] ENT_GLOBAL  = 12'h100;

    // One input item
    typedef struct packed {
        cmd_t                  cmd;
        logic [31:0]           vaddr;
        logic [FRAME_BITS-1:0] target_frame;
        logic                  want_write;
        logic                  want_user;
        logic                  want_wc;
        logic [FRAME_BITS-1:0] spare_frame;
        logic                  spare_ok;
        logic [31:0]           read_data;
    } item_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [31:0] xlat_addr;
        status_t     status;
        logic        last;
    } res_t;

    function automatic res_t mk_res(kind_t k, logic [31:0] addr, logic [31:0] wdata,
                                    logic [31:0] pa, status_t st);
        res_t r;
        r.kind      = k;
        r.mem_addr  = addr;
        r.mem_wdata = wdata;
        r.xlat_addr = pa;
        r.status    = st;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/two_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// two_level_page_table_walker
// Walks a two-level 32-bit page table in external memory for translate, map
// and unmap requests, issuing entry reads and writes as result requests.
// ----------------------------------------------------------------------------
// A request is registered on entry, then handled in combinational logic that
// writes all of its results (up to three) into a small output queue, from
// which they leave one per cycle unless the output stalls. A new request is
// taken as soon as the queue drains to its last waiting result, so the
// sustained rate is one request per cycle when each gives at most one result
// and the output does not stall; a map that installs a directory entry
// occupies the output for its three results. A walk spans several requests:
// a command issues the directory read, and the following memory read
// responses (cmd 3) continue it; commands that arrive mid-walk and responses
// that arrive while idle are dropped without results.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_walker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration: page directory frame
    input  wire logic         cfg_we,
    input  wire logic [19:0]  cfg_wdata,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: vaddr[31:0], target_frame[51:32], want_write[52], want_user[53],
    //        want_wc[54], spare_frame[74:55], spare_ok[75], read_data[107:76]
    input  wire logic [111:0] s_axis_tdata,
    // tuser: cmd[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: mem_addr[31:0], mem_wdata[63:32], xlat_addr[95:64], status[97:96]
    output logic [103:0]      m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import ptw_pkg::*;

    // configuration
    logic [FRAME_BITS-1:0] dir_base_frame_reg;

    // input register
    logic  in_valid_reg;
    item_t in_item_reg;
    item_t s_item;

    // walk state
    phase_t                phase_reg, phase_next;
    cmd_t                  op_kind_reg, op_kind_next;
    logic [31:0]           saved_vaddr_reg, saved_vaddr_next;
    logic [FRAME_BITS-1:0] saved_frame_reg, saved_frame_next;
    logic [2:0]            saved_flags_reg, saved_flags_next;
    logic [FRAME_BITS:0]   saved_spare_reg, saved_spare_next;

    // output queue
    res_t       res_reg [3];
    logic [1:0] res_cnt_reg;
    res_t       batch [3];
    logic [1:0] batch_n;

    logic pop;
    logic load;
    logic s_fire;

    logic [FRAME_BITS-1:0] tbl_frame;
    logic [PAGE_BITS-1:0]  leaf_fl;
    logic                  present;
    logic [31:0]           dir_addr_saved;
    logic [31:0]           leaf_addr;

    // unpack request
    assign s_item.cmd          = cmd_t'(s_axis_tuser);
    assign s_item.vaddr        = s_axis_tdata[31:0];
    assign s_item.target_frame = s_axis_tdata[51:32];
    assign s_item.want_write   = s_axis_tdata[52];
    assign s_item.want_user    = s_axis_tdata[53];
    assign s_item.want_wc      = s_axis_tdata[54];
    assign s_item.spare_frame  = s_axis_tdata[74:55];
    assign s_item.spare_ok     = s_axis_tdata[75];
    assign s_item.read_data    = s_axis_tdata[107:76];

    // handshake control: step when the queue is empty after this cycle
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign load          = in_valid_reg && ((res_cnt_reg == 2'd0) ||
                                            ((res_cnt_reg == 2'd1) && pop));
    assign s_axis_tready = !in_valid_reg || load;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // entry addresses and leaf flags
    assign present        = in_item_reg.read_data[0];
    assign dir_addr_saved = {dir_base_frame_reg,
                             saved_vaddr_reg[31 -: INDEX_BITS], 2'b00};
    assign leaf_addr      = {tbl_frame,
                             saved_vaddr_reg[PAGE_BITS +: INDEX_BITS], 2'b00};

    always_comb
    begin
        leaf_fl = ENT_PRESENT;
        if (saved_flags_reg[0])
        begin
            leaf_fl = leaf_fl | ENT_WRITE;
        end
        if (saved_flags_reg[1])
        begin
            leaf_fl = leaf_fl | ENT_USER;
        end
        else
        begin
            leaf_fl = leaf_fl | ENT_GLOBAL;
        end
        if (saved_flags_reg[2])
        begin
            leaf_fl = leaf_fl | ENT_PAT;
        end
    end

    // table frame: from the directory entry, or the spare frame on a fresh map
    always_comb
    begin
        if (op_kind_reg == CMD_MAP && !present)
        begin
            tbl_frame = saved_spare_reg[FRAME_BITS-1:0];
        end
        else
        begin
            tbl_frame = in_item_reg.read_data[31:PAGE_BITS];
        end
    end

    // one walk step: next state and the results of the registered request
    always_comb
    begin
        phase_next       = phase_reg;
        op_kind_next     = op_kind_reg;
        saved_vaddr_next = saved_vaddr_reg;
        saved_frame_next = saved_frame_reg;
        saved_flags_next = saved_flags_reg;
        saved_spare_next = saved_spare_reg;
        batch_n          = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            batch[i] = mk_res(KIND_READ, 32'd0, 32'd0, 32'd0, ST_OK);
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_item_reg.cmd != CMD_RESP)
                begin
                    op_kind_next     = in_item_reg.cmd;
                    saved_vaddr_next = in_item_reg.vaddr;
                    saved_frame_next = in_item_reg.target_frame;
                    saved_flags_next = {in_item_reg.want_wc, in_item_reg.want_user,
                                        in_item_reg.want_write};
                    saved_spare_next = {in_item_reg.spare_ok, in_item_reg.spare_frame};
                    batch[0] = mk_res(KIND_READ,
                                      {dir_base_frame_reg,
                                       in_item_reg.vaddr[31 -: INDEX_BITS], 2'b00},
                                      32'd0, 32'd0, ST_OK);
                    batch_n    = 2'd1;
                    phase_next = PH_WAIT_DIR;
                end
            end
            PH_WAIT_DIR:
            begin
                if (in_item_reg.cmd == CMD_RESP)
                begin
                    phase_next = PH_IDLE;
                    priority if (op_kind_reg == CMD_XLATE)
                    begin
                        if (!present)
                        begin
                            batch[0] = mk_res(KIND_DONE, 32'd0, 32'd0, 32'd0, ST_NOT_PRS);
                        end
                        else
                        begin
                            batch[0]   = mk_res(KIND_READ, leaf_addr, 32'd0, 32'd0, ST_OK);
                            phase_next = PH_WAIT_LEAF;
                        end
                        batch_n = 2'd1;
                    end
                    else if (op_kind_reg == CMD_MAP)
                    begin
                        priority if (present)
                        begin
                            batch[0] = mk_res(KIND_WRITE, leaf_addr,
                                              {saved_frame_reg, leaf_fl}, 32'd0, ST_OK);
                            batch[1] = mk_res(KIND_DONE, 32'd0, 32'd0, 32'd0, ST_OK);
                            batch_n  = 2'd2;
                        end
                        else if (!saved_spare_reg[FRAME_BITS])
                        begin
                            batch[0] = mk_res(KIND_DONE, 32'd0, 32'd0, 32'd0, ST_NO_MEM);
                            batch_n  = 2'd1;
                        end
                        else
                        begin
                            batch[0] = mk_res(KIND_WRITE, dir_addr_saved,
                                              {tbl_frame, ENT_PRESENT | ENT_WRITE | ENT_USER},
                                              32'd0, ST_OK);
                            batch[1] = mk_res(KIND_WRITE, leaf_addr,
                                              {saved_frame_reg, leaf_fl}, 32'd0, ST_OK);
                            batch[2] = mk_res(KIND_DONE, 32'd0, 32'd0, 32'd0, ST_OK);
                            batch_n  = 2'd3;
                        end
                    end
                    else
                    begin
                        if (present)
                        begin
                            batch[0] = mk_res(KIND_WRITE, leaf_addr, 32'd0, 32'd0, ST_OK);
                            batch[1] = mk_res(KIND_DONE, 32'd0, 32'd0, 32'd0, ST_OK);
                            batch_n  = 2'd2;
                        end
                        else
                        begin
                            batch[0] = mk_res(KIND_DONE, 32'd0, 32'd0, 32'd0, ST_OK);
                            batch_n  = 2'd1;
                        end
                    end
                end
            end
            PH_WAIT_LEAF:
            begin
                if (in_item_reg.cmd == CMD_RESP)
                begin
                    phase_next = PH_IDLE;
                    if (!present)
                    begin
                        batch[0] = mk_res(KIND_DONE, 32'd0, 32'd0, 32'd0, ST_NOT_PRS);
                    end
                    else
                    begin
                        batch[0] = mk_res(KIND_DONE, 32'd0, 32'd0,
                                          {in_item_reg.read_data[31:PAGE_BITS],
                                           saved_vaddr_reg[PAGE_BITS-1:0]}, ST_OK);
                    end
                    batch_n = 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // mark the final result of this request
        if (batch_n != 2'd0)
        begin
            batch[batch_n - 2'd1].last = 1'b1;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_base_frame_reg <= '0;
        end
        else if (cfg_we)
        begin
            dir_base_frame_reg <= cfg_wdata;
        end
    end

    // input register: hold the request until it is stepped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= s_item;
        end
    end

    // walk state: advance on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            op_kind_reg     <= CMD_XLATE;
            saved_vaddr_reg <= '0;
            saved_frame_reg <= '0;
            saved_flags_reg <= '0;
            saved_spare_reg <= '0;
        end
        else if (load)
        begin
            phase_reg       <= phase_next;
            op_kind_reg     <= op_kind_next;
            saved_vaddr_reg <= saved_vaddr_next;
            saved_frame_reg <= saved_frame_next;
            saved_flags_reg <= saved_flags_next;
            saved_spare_reg <= saved_spare_next;
        end
    end

    // output queue count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            res_cnt_reg <= batch_n;
        end
        else if (pop)
        begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    // output queue entries: load a batch or shift toward the head
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg[0] <= batch[0];
            res_reg[1] <= batch[1];
            res_reg[2] <= batch[2];
        end
        else if (pop)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    // drive the result stream from the queue head
    assign m_axis_tvalid = (res_cnt_reg != 2'd0);
    assign m_axis_tuser  = res_reg[0].kind;
    assign m_axis_tlast  = res_reg[0].last;
    assign m_axis_tdata  = {6'd0, res_reg[0].status, res_reg[0].xlat_addr,
                            res_reg[0].mem_wdata, res_reg[0].mem_addr};

    // the queue never holds more than one request's results
    assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg != 2'd3 || !res_reg[0].last)
        else $error("final result of a request is not at the queue tail");

    // the last waiting result carries tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_cnt_reg == 2'd1) |-> m_axis_tlast)
        else $error("last queued result without tlast");

    // a done result always ends its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
        else $error("done result not marked last");

    // a pending read request means a walk is waiting for its response
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_READ) |-> (phase_reg != PH_IDLE))
        else $error("read request issued while the walker is idle");

endmodule

`default_nettype wire
